### hdl/tea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types and constants of the TEA block cipher pipeline.
// ----------------------------------------------------------------------------
package tea_pkg;

    localparam int WORD_W = 32;
    localparam int ROUND_COUNT_DEF = 32;
    localparam int CFG_INDEX_W = 2;

    localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD0 = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD1 = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD3 = 2'd3;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t key0;
        word_t key1;
        word_t key2;
        word_t key3;
    } key_t;

    // One beat travelling down the chain of half-round cells.
    typedef struct packed {
        logic  valid;
        logic  command;
        word_t word_a;
        word_t word_b;
    } beat_t;

    typedef struct packed {
        word_t word_a;
        word_t word_b;
    } result_t;

endpackage
`default_nettype wire

### hdl/tea_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tea_cell
// One TEA half-round with its output register. Even cells update the first
// word when encrypting, odd cells the second; decryption swaps the roles.
// ----------------------------------------------------------------------------
module tea_cell #(
    parameter logic                PHASE   = 1'b0,
    parameter logic [31:0]         ENC_SUM = 32'h0,
    parameter logic [31:0]         DEC_SUM = 32'h0
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          advance,
    input  wire tea_pkg::key_t key,
    input  wire tea_pkg::beat_t beat_in,
    output tea_pkg::beat_t     beat_out
);

    tea_pkg::beat_t beat_reg;
    tea_pkg::beat_t beat_next;

    logic           decrypt;
    logic           src_is_b;
    tea_pkg::word_t src_word;
    tea_pkg::word_t dst_word;
    tea_pkg::word_t key_left;
    tea_pkg::word_t key_right;
    tea_pkg::word_t round_sum;
    tea_pkg::word_t mix;
    tea_pkg::word_t new_word;

    always_comb begin
        decrypt   = (beat_in.command == tea_pkg::CMD_DECRYPT);
        // The first word is mixed from the second in the encrypt-even and
        // decrypt-odd half-rounds.
        src_is_b  = ~(PHASE ^ decrypt);
        src_word  = src_is_b ? beat_in.word_b : beat_in.word_a;
        dst_word  = src_is_b ? beat_in.word_a : beat_in.word_b;
        key_left  = src_is_b ? key.key0 : key.key2;
        key_right = src_is_b ? key.key1 : key.key3;
        round_sum = decrypt ? DEC_SUM : ENC_SUM;
        mix       = ((src_word << 4) + key_left) ^ (src_word + round_sum)
                  ^ ((src_word >> 5) + key_right);
        new_word  = decrypt ? (dst_word - mix) : (dst_word + mix);

        beat_next = beat_in;
        if (src_is_b) begin
            beat_next.word_a = new_word;
        end else begin
            beat_next.word_b = new_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg.valid <= 1'b0;
        end else if (advance) begin
            beat_reg <= beat_next;
        end
    end

    assign beat_out = beat_reg;

endmodule
`default_nettype wire

### hdl/tea_skid.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tea_skid
// Two-entry output buffer. The chain stalls only on the registered full
// flag, so the result side never reaches back to the input side in logic.
// ----------------------------------------------------------------------------
module tea_skid (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    input  wire tea_pkg::result_t in_data,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output tea_pkg::result_t     out_data
);

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             spare_valid_reg;
    logic             spare_valid_next;
    tea_pkg::result_t out_data_reg;
    tea_pkg::result_t out_data_next;
    tea_pkg::result_t spare_data_reg;
    tea_pkg::result_t spare_data_next;

    always_comb begin
        out_valid_next   = out_valid_reg;
        spare_valid_next = spare_valid_reg;
        out_data_next    = out_data_reg;
        spare_data_next  = spare_data_reg;
        if (out_valid_reg && !out_ready) begin
            if (in_valid) begin
                spare_valid_next = 1'b1;
                spare_data_next  = in_data;
            end
        end else if (spare_valid_reg) begin
            out_valid_next = 1'b1;
            out_data_next  = spare_data_reg;
            if (in_valid) begin
                spare_data_next = in_data;
            end else begin
                spare_valid_next = 1'b0;
            end
        end else begin
            out_valid_next = in_valid;
            out_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else begin
            out_valid_reg   <= out_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
        out_data_reg   <= out_data_next;
        spare_data_reg <= spare_data_next;
    end

    assign in_ready  = ~spare_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // The spare entry only fills behind a held output beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        spare_valid_reg |-> out_valid_reg)
        else $error("tea_skid: spare entry valid without output beat");

    // The chain must freeze while the buffer is full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid |-> in_ready)
        else $error("tea_skid: beat pushed into full buffer");

    // A taken beat with a spare waiting is followed by the spare.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_ready && spare_valid_reg) |=>
            (out_valid_reg && out_data_reg == $past(spare_data_reg)))
        else $error("tea_skid: spare beat lost");
`endif

endmodule
`default_nettype wire

### hdl/tea_block_cipher.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted input beat passes one register per TEA half-round plus the output
// buffer on its way to its result beat. Throughput: one block per cycle; the
// chain of half-round cells advances whenever the two-entry output buffer is
// not full. Reset clears the key registers to zero and empties the chain and
// buffer.
// ----------------------------------------------------------------------------
// tea_block_cipher
// TEA encryption and decryption of 64-bit blocks under a 128-bit key.
// ----------------------------------------------------------------------------
module tea_block_cipher #(
    parameter int ROUND_COUNT = tea_pkg::ROUND_COUNT_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              cfg_write,
    input  wire logic [tea_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [tea_pkg::WORD_W-1:0]        cfg_data,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_command,
    input  wire logic [tea_pkg::WORD_W-1:0]        s_block_low,
    input  wire logic [tea_pkg::WORD_W-1:0]        s_block_high,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [tea_pkg::WORD_W-1:0]             m_result_low,
    output logic [tea_pkg::WORD_W-1:0]             m_result_high
);

    localparam int CELL_COUNT = 2 * ROUND_COUNT;

    tea_pkg::key_t    key_reg;
    tea_pkg::beat_t   stage [0:CELL_COUNT];
    tea_pkg::result_t last_data;
    tea_pkg::result_t out_data;
    logic             buf_ready;
    logic             advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                tea_pkg::REG_KEY_WORD0: key_reg.key0 <= cfg_data;
                tea_pkg::REG_KEY_WORD1: key_reg.key1 <= cfg_data;
                tea_pkg::REG_KEY_WORD2: key_reg.key2 <= cfg_data;
                tea_pkg::REG_KEY_WORD3: key_reg.key3 <= cfg_data;
            endcase
        end
    end

    // The whole chain moves together while the output buffer has room.
    assign advance = buf_ready;
    assign s_ready = buf_ready;

    always_comb begin
        stage[0].valid   = s_valid & buf_ready;
        stage[0].command = s_command;
        stage[0].word_a  = s_block_low;
        stage[0].word_b  = s_block_high;
    end

    for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
        localparam int          ROUND    = i / 2;
        localparam logic [63:0] ENC_FULL = 64'(tea_pkg::TEA_DELTA) * 64'(ROUND + 1);
        localparam logic [63:0] DEC_FULL = 64'(tea_pkg::TEA_DELTA) * 64'(ROUND_COUNT - ROUND);

        tea_cell #(
            .PHASE   (1'(i % 2)),
            .ENC_SUM (ENC_FULL[31:0]),
            .DEC_SUM (DEC_FULL[31:0])
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .key      (key_reg),
            .beat_in  (stage[i]),
            .beat_out (stage[i+1])
        );
    end

    assign last_data.word_a = stage[CELL_COUNT].word_a;
    assign last_data.word_b = stage[CELL_COUNT].word_b;

    tea_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (stage[CELL_COUNT].valid & buf_ready),
        .in_data   (last_data),
        .in_ready  (buf_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_result_low  = out_data.word_a;
    assign m_result_high = out_data.word_b;

endmodule
`default_nettype wire

### bench/tea_block_cipher_tb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tea_block_cipher_tb
// Self-checking bench for the TEA block cipher. Blocks are sent for encryption
// and decryption under a series of keys. A bit-exact model of TEA computes
// each expected result. Results are checked in order while both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
module tea_block_cipher_tb;

    localparam int ROUNDS        = tea_pkg::ROUND_COUNT_DEF;
    localparam int LATENCY       = 2 * ROUNDS + 1;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int PHASE_BLOCKS  = 180;
    localparam int HISTORY_DEPTH = 16;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_write     = 1'b0;
    logic [tea_pkg::CFG_INDEX_W-1:0] cfg_index = tea_pkg::REG_KEY_WORD0;
    tea_pkg::word_t cfg_data      = '0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic        s_command     = tea_pkg::CMD_ENCRYPT;
    tea_pkg::word_t s_block_low   = '0;
    tea_pkg::word_t s_block_high  = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    tea_pkg::word_t m_result_low;
    tea_pkg::word_t m_result_high;

    tea_pkg::key_t    key_model     = '0;
    tea_pkg::result_t pending_blocks[$];
    tea_pkg::result_t cipher_history[$];

    int          feed_gap_level   = 0;
    int          drain_stall_level = 0;
    int          stall_left       = 0;
    int          idle_cycles      = 0;
    int          fault_count      = 0;
    int          blocks_sent      = 0;
    int          decrypts_sent    = 0;
    int          results_checked  = 0;
    int          key_loads        = 0;

    tea_block_cipher dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_block_low   (s_block_low),
        .s_block_high  (s_block_high),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_low  (m_result_low),
        .m_result_high (m_result_high)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // TEA model
    // ------------------------------------------------------------------
    function automatic tea_pkg::word_t half_round_mix(tea_pkg::word_t w,
                                                      tea_pkg::word_t sum,
                                                      tea_pkg::word_t kl,
                                                      tea_pkg::word_t kr);
        return ((w << 4) + kl) ^ (w + sum) ^ ((w >> 5) + kr);
    endfunction

    function automatic tea_pkg::result_t tea_cipher(logic cmd, tea_pkg::word_t low,
                                                    tea_pkg::word_t high,
                                                    tea_pkg::key_t k);
        tea_pkg::word_t   a;
        tea_pkg::word_t   b;
        tea_pkg::word_t   sum;
        tea_pkg::result_t res;
        int               r;
        a = low;
        b = high;
        if (cmd == tea_pkg::CMD_ENCRYPT) begin
            sum = '0;
            for (r = 0; r < ROUNDS; r++) begin
                sum = sum + tea_pkg::TEA_DELTA;
                a = a + half_round_mix(b, sum, k.key0, k.key1);
                b = b + half_round_mix(a, sum, k.key2, k.key3);
            end
        end else begin
            // Decryption walks the sum back down from delta times the round count.
            sum = tea_pkg::TEA_DELTA * tea_pkg::word_t'(ROUNDS);
            for (r = 0; r < ROUNDS; r++) begin
                b = b - half_round_mix(a, sum, k.key2, k.key3);
                a = a - half_round_mix(b, sum, k.key0, k.key1);
                sum = sum - tea_pkg::TEA_DELTA;
            end
        end
        res.word_a = a;
        res.word_b = b;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------
    function automatic int gap_length();
        int q;
        q = $urandom_range(0, 19);
        if (q < 15) return $urandom_range(1, 3);
        if (q < 19) return $urandom_range(4, 12);
        return $urandom_range(30, 90);
    endfunction

    function automatic int pick_gap(int level);
        if (level == 0) return 0;
        if ($urandom_range(0, 99) < (level == 1 ? 70 : 35)) return 0;
        return gap_length();
    endfunction

    function automatic tea_pkg::word_t pick_word();
        int q;
        q = $urandom_range(0, 9);
        case (q)
            0: return '0;
            1: return '1;
            2: return tea_pkg::word_t'(1) << $urandom_range(0, tea_pkg::WORD_W - 1);
            3: return ~(tea_pkg::word_t'(1) << $urandom_range(0, tea_pkg::WORD_W - 1));
            default: return tea_pkg::word_t'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------
    task automatic send_block(input logic cmd, input tea_pkg::word_t low,
                              input tea_pkg::word_t high);
        int               gap;
        tea_pkg::result_t expected;
        gap = pick_gap(feed_gap_level);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_block_low  <= low;
        s_block_high <= high;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected = tea_cipher(cmd, low, high, key_model);
        pending_blocks.push_back(expected);
        blocks_sent++;
        if (cmd == tea_pkg::CMD_DECRYPT) begin
            decrypts_sent++;
        end else begin
            cipher_history.push_back(expected);
            if (cipher_history.size() > HISTORY_DEPTH) void'(cipher_history.pop_front());
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge aclk);
    endtask

    task automatic write_key_reg(input logic [tea_pkg::CFG_INDEX_W-1:0] index,
                                 input tea_pkg::word_t value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
    endtask

    // The key may only change while no block is in flight.
    task automatic load_key(input tea_pkg::key_t k);
        wait_idle();
        write_key_reg(tea_pkg::REG_KEY_WORD0, k.key0);
        write_key_reg(tea_pkg::REG_KEY_WORD1, k.key1);
        write_key_reg(tea_pkg::REG_KEY_WORD2, k.key2);
        write_key_reg(tea_pkg::REG_KEY_WORD3, k.key3);
        cfg_write <= 1'b0;
        key_model = k;
        cipher_history.delete();
        key_loads++;
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and in-order checking
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (drain_stall_level != 0 &&
                $urandom_range(0, 99) < (drain_stall_level == 1 ? 10 : 35)) begin
                stall_left <= gap_length();
            end
        end
    end

    always @(posedge aclk) begin
        tea_pkg::result_t expected;
        if (aresetn && m_valid && m_ready) begin
            if (pending_blocks.size() == 0) begin
                $display("%0t: result beat with nothing expected: low %h high %h",
                         $time, m_result_low, m_result_high);
                fault_count++;
            end else begin
                expected = pending_blocks.pop_front();
                if (m_result_low !== expected.word_a) begin
                    $display("%0t: result_low mismatch: expected %h actual %h",
                             $time, expected.word_a, m_result_low);
                    fault_count++;
                end
                if (m_result_high !== expected.word_b) begin
                    $display("%0t: result_high mismatch: expected %h actual %h",
                             $time, expected.word_b, m_result_high);
                    fault_count++;
                end
                results_checked++;
            end
        end
    end

    // Ends the run if neither channel moves a beat for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_MAX) begin
            $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_MAX);
            $display("tea_block_cipher verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_key();
        // The key registers come out of reset as zero.
        feed_gap_level    = 0;
        drain_stall_level = 0;
        send_block(tea_pkg::CMD_ENCRYPT, '0, '0);
        send_block(tea_pkg::CMD_ENCRYPT, '1, '1);
        send_block(tea_pkg::CMD_ENCRYPT, '0, '1);
        send_block(tea_pkg::CMD_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
        send_block(tea_pkg::CMD_DECRYPT, '0, '0);
        send_block(tea_pkg::CMD_DECRYPT, '1, '1);
        send_block(tea_pkg::CMD_DECRYPT, '1, '0);
        send_block(tea_pkg::CMD_DECRYPT, 32'h0000_0001, 32'h8000_0000);
    endtask

    task automatic test_key_extremes();
        tea_pkg::key_t k;
        k = '1;
        load_key(k);
        send_block(tea_pkg::CMD_ENCRYPT, '0, '0);
        send_block(tea_pkg::CMD_ENCRYPT, '1, '1);
        send_block(tea_pkg::CMD_DECRYPT, '0, '1);
        send_block(tea_pkg::CMD_DECRYPT, '1, '0);
        k = {32'hFFFF_FFFF, 32'h0000_0000, 32'hAAAA_AAAA, 32'h5555_5555};
        load_key(k);
        send_block(tea_pkg::CMD_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF);
        send_block(tea_pkg::CMD_DECRYPT, 32'h89AB_CDEF, 32'h0123_4567);
    endtask

    task automatic test_round_trip();
        tea_pkg::key_t    k;
        tea_pkg::result_t c;
        int               i;
        k = {tea_pkg::word_t'($urandom), tea_pkg::word_t'($urandom),
             tea_pkg::word_t'($urandom), tea_pkg::word_t'($urandom)};
        load_key(k);
        feed_gap_level    = 1;
        drain_stall_level = 1;
        for (i = 0; i < 3; i++) send_block(tea_pkg::CMD_ENCRYPT, pick_word(), pick_word());
        for (i = 0; i < 3; i++) begin
            c = cipher_history[i];
            send_block(tea_pkg::CMD_DECRYPT, c.word_a, c.word_b);
        end
    endtask

    task automatic test_random_traffic();
        tea_pkg::key_t    k;
        tea_pkg::result_t c;
        int               phase;
        int               i;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                1: k = '1;
                3: k = '0;
                4: k = {32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hFFFF_0000, 32'h0000_FFFF};
                default: k = {tea_pkg::word_t'($urandom), tea_pkg::word_t'($urandom),
                              tea_pkg::word_t'($urandom), tea_pkg::word_t'($urandom)};
            endcase
            load_key(k);
            feed_gap_level    = phase % 3;
            drain_stall_level = (phase / 2) % 3;
            for (i = 0; i < PHASE_BLOCKS; i++) begin
                // A third of the decryptions undo a recent ciphertext of this key.
                if ($urandom_range(0, 1) == 1) begin
                    if (cipher_history.size() != 0 && $urandom_range(0, 2) == 0) begin
                        c = cipher_history[$urandom_range(0, cipher_history.size() - 1)];
                        send_block(tea_pkg::CMD_DECRYPT, c.word_a, c.word_b);
                    end else begin
                        send_block(tea_pkg::CMD_DECRYPT, pick_word(), pick_word());
                    end
                end else begin
                    send_block(tea_pkg::CMD_ENCRYPT, pick_word(), pick_word());
                end
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_key();
        test_key_extremes();
        test_round_trip();
        test_random_traffic();

        wait_idle();
        repeat (LATENCY + 8) @(posedge aclk);

        $display("Sent %0d blocks (%0d decryptions) under %0d key loads, %0d results checked.",
                 blocks_sent, decrypts_sent, key_loads, results_checked);
        $display("Input gaps and output stalls ranged from none to long pauses.");
        if (fault_count == 0 && pending_blocks.size() == 0) begin
            $display("tea_block_cipher verification clean");
        end else begin
            $display("%0d faults, %0d results never arrived", fault_count,
                     pending_blocks.size());
            $display("tea_block_cipher verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

### tea_block_cipher.f
hdl/tea_pkg.sv
hdl/tea_cell.sv
hdl/tea_skid.sv
hdl/tea_block_cipher.sv
bench/tea_block_cipher_tb.sv
